// ----- hdl/bds_pkg.sv -----
// Shared types and constants for the 2x2 box-average downscaler.
package bds_pkg;

    localparam int CH_W        = 16;
    localparam int PIX_W       = 3 * CH_W;
    localparam int PAIR_W      = CH_W + 1;
    localparam int SLOT_W      = 13;
    localparam int CNT_W       = 12;
    localparam int CFG_W       = 13;
    localparam int HEIGHT_MAX  = 4096;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic              emit;
        logic              last;
        logic [SLOT_W-1:0] slot;
        logic [PAIR_W-1:0] sum_r;
        logic [PAIR_W-1:0] sum_g;
        logic [PAIR_W-1:0] sum_b;
    } t_op;

endpackage

// ----- hdl/box_downscale_2x2.sv -----
// Top level of the 2x2 box-average image downscaler.
// Pixels enter in raster order at one item per clock while s_axis_tready is high; the front
// end takes one pixel per clock and issues at most one line-memory op per column pair, which
// the back end retires at one per clock unless the output stalls, so the input stalls only
// when the op queue fills behind a stalled output. m_axis_tvalid rises once the op of the
// pixel completing a block has passed the queue, memory read and output register in turn.
// The line memory holds MAX_WIDTH/2 entries and needs no clearing pass.
// Writing width or height restarts the image at its first pixel; write only while idle.
module box_downscale_2x2 #(
    parameter int MAX_WIDTH    = 4096,
    parameter int CHANNEL_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [bds_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [bds_pkg::PIX_W-1:0] s_axis_tdata,  // red_in, green_in, blue_in
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [bds_pkg::PIX_W-1:0] m_axis_tdata,  // red_out, green_out, blue_out
    output logic                      m_axis_tlast   // last_of_image
);
    import bds_pkg::*;

    logic accept, push, pop, full, empty;
    t_op  op, head;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && !full;

    bds_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_pix       (s_axis_tdata),
        .o_push      (push),
        .o_op        (op)
    );

    bds_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (op),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    bds_back #(
        .MAX_WIDTH    (MAX_WIDTH),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

// ----- hdl/bds_front.sv -----
// Front end: accepts pixels, tracks position, forms column-pair sums, issues ops.
module bds_front #(
    parameter int MAX_WIDTH    = 4096,
    parameter int CHANNEL_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [bds_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                   i_accept,
    input  logic [bds_pkg::PIX_W-1:0] i_pix,
    output logic                   o_push,
    output bds_pkg::t_op           o_op
);
    import bds_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH / 2;

    logic [CFG_W-1:0]        r_width, r_height;
    logic [CNT_W-1:0]        r_col, r_row;
    logic [CHANNEL_BITS-1:0] r_held_r, r_held_g, r_held_b;

    logic [CFG_W-1:0]        w_eff, h_eff, w_even, h_even;
    logic [CFG_W-1:0]        col_inc, row_inc;
    logic [CHANNEL_BITS-1:0] pix_r, pix_g, pix_b;
    logic [CNT_W-2:0]        slot;
    logic                    slot_ok, last_row, last_col;

    assign pix_r = i_pix[CHANNEL_BITS-1:0];
    assign pix_g = i_pix[CH_W +: CHANNEL_BITS];
    assign pix_b = i_pix[2*CH_W +: CHANNEL_BITS];

    always_comb begin
        if (r_width == '0) begin
            w_eff = CFG_W'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            w_eff = CFG_W'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = CFG_W'(1);
        end else if (32'(r_height) > HEIGHT_MAX) begin
            h_eff = CFG_W'(HEIGHT_MAX);
        end else begin
            h_eff = r_height;
        end
    end

    assign w_even   = {w_eff[CFG_W-1:1], 1'b0};
    assign h_even   = {h_eff[CFG_W-1:1], 1'b0};
    assign last_col = (w_even != '0) && ({1'b0, r_col} == w_even - CFG_W'(1));
    assign last_row = (h_even != '0) && ({1'b0, r_row} == h_even - CFG_W'(1));
    assign col_inc  = {1'b0, r_col} + CFG_W'(1);
    assign row_inc  = {1'b0, r_row} + CFG_W'(1);
    assign slot     = r_col[CNT_W-1:1];
    assign slot_ok  = 32'(slot) < LINE_DEPTH;

    always_comb begin
        o_push     = i_accept && r_col[0] && slot_ok;
        o_op.emit  = r_row[0];
        o_op.last  = last_row && last_col;
        o_op.slot  = SLOT_W'(slot);
        o_op.sum_r = PAIR_W'({1'b0, r_held_r} + {1'b0, pix_r});
        o_op.sum_g = PAIR_W'({1'b0, r_held_g} + {1'b0, pix_g});
        o_op.sum_b = PAIR_W'({1'b0, r_held_b} + {1'b0, pix_b});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W'(640);
            r_height <= CFG_W'(480);
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_WIDTH) begin
                r_width <= i_cfg_data;
            end else begin
                r_height <= i_cfg_data;
            end
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            if (col_inc >= w_eff) begin
                r_col <= '0;
                if (row_inc >= h_eff) begin
                    r_row <= '0;
                end else begin
                    r_row <= row_inc[CNT_W-1:0];
                end
            end else begin
                r_col <= col_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && !r_col[0]) begin
            r_held_r <= pix_r;
            r_held_g <= pix_g;
            r_held_b <= pix_b;
        end
    end

endmodule

// ----- hdl/bds_queue.sv -----
// Short op queue between front and back ends.
module bds_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  bds_pkg::t_op i_op,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_empty,
    output bds_pkg::t_op o_head
);
    import bds_pkg::*;

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

// ----- hdl/bds_back.sv -----
// Back end: line memory of pair sums, block sum and rounding, output register.
module bds_back #(
    parameter int MAX_WIDTH    = 4096,
    parameter int CHANNEL_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_empty,
    input  bds_pkg::t_op              i_head,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [bds_pkg::PIX_W-1:0] o_data,
    output logic                      o_last
);
    import bds_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int SW         = CHANNEL_BITS + 1;
    localparam int TW         = CHANNEL_BITS + 2;

    logic [3*SW-1:0] r_line [LINE_DEPTH];
    logic [3*SW-1:0] r_rd, wr_data;
    logic [3*SW-1:0] r_a_pair;
    logic            r_a_valid, r_a_last;
    logic            r_o_valid, r_o_last;
    logic [PIX_W-1:0] r_o_data;

    logic            out_adv, a_free, pop_write, pop_emit;
    logic [AW-1:0]   addr;
    logic [TW-1:0]   tot_r, tot_g, tot_b;

    assign addr      = i_head.slot[AW-1:0];
    assign wr_data   = {i_head.sum_b[SW-1:0], i_head.sum_g[SW-1:0], i_head.sum_r[SW-1:0]};
    assign out_adv   = !r_o_valid || i_ready;
    assign a_free    = !r_a_valid || out_adv;
    assign pop_write = !i_empty && !i_head.emit;
    assign pop_emit  = !i_empty && i_head.emit && a_free;
    assign o_pop     = pop_write || pop_emit;

    always_ff @(posedge i_clk) begin
        if (pop_write) begin
            r_line[addr] <= wr_data;
        end
        if (pop_emit) begin
            r_rd     <= r_line[addr];
            r_a_pair <= wr_data;
            r_a_last <= i_head.last;
        end
    end

    assign tot_r = TW'(r_rd[SW-1:0]) + TW'(r_a_pair[SW-1:0]) + TW'(2);
    assign tot_g = TW'(r_rd[SW +: SW]) + TW'(r_a_pair[SW +: SW]) + TW'(2);
    assign tot_b = TW'(r_rd[2*SW +: SW]) + TW'(r_a_pair[2*SW +: SW]) + TW'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (a_free) begin
                r_a_valid <= pop_emit;
            end
            if (out_adv) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_a_valid) begin
            r_o_data <= {CH_W'(tot_b[TW-1:2]), CH_W'(tot_g[TW-1:2]), CH_W'(tot_r[TW-1:2])};
            r_o_last <= r_a_last;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;
    assign o_last  = r_o_last;

endmodule
